// ===== rtl/core/circular_list_engine_core_assert.svh =====
// Assertion macros shared by the circular list engine RTL.
`ifndef CIRCULAR_LIST_ENGINE_CORE_ASSERT_SVH
`define CIRCULAR_LIST_ENGINE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define CLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define CLE_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define CLE_ASSERT(lbl, prop, msg)
`define CLE_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/core/cle_pkg.sv =====
// Shared constants for the circular list engine.
`default_nettype none
package cle_pkg;

    localparam int CAPACITY = 32;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int KIND_W   = 3;

    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WALK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/core/circular_list_engine_core.sv =====
// Circular doubly linked list engine: top level with node memories and sequencer.
//
// Keeps up to 32 nonzero keys in a circular doubly linked list whose key, next and
// prev fields live in synchronous memories with registered reads. One
// input word (tuser = kind, tdata = key) is taken at a time. Add passes through
// ST_ADD_A and ST_ADD_B before ST_RESP presents its result; search and remove
// follow the chain of dependent reads along the next links one node per cycle;
// walk emits count result words, one per cycle while the output is taken; clear
// and refused words go straight to ST_RESP. A new word is accepted while the
// previous result still waits in the output register.
// There is no clearing pass: the contents of unused slots are never used.
`default_nettype none
`include "circular_list_engine_core_assert.svh"
module circular_list_engine_core
    import cle_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [31:0]       i_s_tdata,   // [31:0] key
    input  wire logic [KIND_W-1:0] i_s_tuser,   // [2:0] kind
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic      [39:0]       o_m_tdata,   // [31:0] item_key, [37:32] entry_count
    output logic                   o_m_tlast,   // last
    output logic      [0:0]        o_m_tuser    // [0] status
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_ADD_A = 5'b00100,
        ST_ADD_B = 5'b01000,
        ST_RESP  = 5'b10000
    } t_state;

    // node memories
    logic [KEY_W-1:0]  key_mem  [CAPACITY];
    logic [SLOT_W-1:0] next_mem [CAPACITY];
    logic [SLOT_W-1:0] prev_mem [CAPACITY];

    logic [KEY_W-1:0]  r_rd_key;
    logic [SLOT_W-1:0] r_rd_next;
    logic [SLOT_W-1:0] r_rd_prev;
    logic [SLOT_W-1:0] rd_addr;

    logic              key_we;
    logic [SLOT_W-1:0] key_waddr;
    logic              next_we;
    logic [SLOT_W-1:0] next_waddr;
    logic [SLOT_W-1:0] next_wdata;
    logic              prev_we;
    logic [SLOT_W-1:0] prev_waddr;
    logic [SLOT_W-1:0] prev_wdata;

    t_state              r_state, n_state;
    logic [CAPACITY-1:0] r_used, n_used;
    logic [SLOT_W-1:0]   r_head, n_head;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [SLOT_W-1:0]   r_idx, n_idx;
    logic [SLOT_W-1:0]   r_cur;
    logic                r_res_status, n_res_status;

    logic                r_out_valid, n_out_valid;
    logic                r_out_status, n_out_status;
    logic [KEY_W-1:0]    r_out_key, n_out_key;
    logic                r_out_last, n_out_last;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;

    logic [SLOT_W-1:0]   free_slot;
    logic                in_accept;
    logic                out_free;
    logic                out_load;
    logic                walk_last;
    logic [SLOT_W-1:0]   after_slot;
    logic [SLOT_W-1:0]   link_head;

    cle_free_slot u_free_slot (
        .i_used (r_used),
        .o_slot (free_slot)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign walk_last  = (COUNT_W'(r_idx) + COUNT_W'(1)) == r_count;
    assign after_slot = (r_count == '0) ? r_slot : r_rd_next;
    assign link_head  = (r_count == '0) ? r_slot : r_head;

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_head       = r_head;
        n_count      = r_count;
        n_kind       = r_kind;
        n_key        = r_key;
        n_slot       = r_slot;
        n_idx        = r_idx;
        n_res_status = r_res_status;
        rd_addr      = r_cur;
        out_load     = 1'b0;
        n_out_status = r_out_status;
        n_out_key    = r_out_key;
        n_out_last   = r_out_last;
        n_out_count  = r_out_count;
        key_we       = 1'b0;
        key_waddr    = r_slot;
        next_we      = 1'b0;
        next_waddr   = r_slot;
        next_wdata   = after_slot;
        prev_we      = 1'b0;
        prev_waddr   = after_slot;
        prev_wdata   = r_slot;

        unique case (r_state)
            ST_IDLE: begin
                rd_addr = r_head;
                if (in_accept) begin
                    n_kind       = i_s_tuser;
                    n_key        = i_s_tdata;
                    n_slot       = free_slot;
                    n_idx        = '0;
                    n_res_status = STATUS_ERR;
                    n_state      = ST_RESP;
                    unique case (i_s_tuser)
                        KIND_ADD: begin
                            if (i_s_tdata != '0 && r_count != COUNT_W'(CAPACITY)) begin
                                n_state = ST_ADD_A;
                            end
                        end
                        KIND_REMOVE, KIND_SEARCH: begin
                            if (i_s_tdata != '0 && r_count != '0) begin
                                n_state = ST_SCAN;
                            end
                        end
                        KIND_WALK: begin
                            if (r_count != '0) begin
                                n_state = ST_SCAN;
                            end
                        end
                        KIND_CLEAR: begin
                            n_used       = '0;
                            n_head       = '0;
                            n_count      = '0;
                            n_res_status = STATUS_OK;
                        end
                        default: begin
                            n_res_status = STATUS_ERR;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_kind == KIND_WALK) begin
                    if (out_free) begin
                        out_load     = 1'b1;
                        n_out_status = STATUS_OK;
                        n_out_key    = r_rd_key;
                        n_out_last   = walk_last;
                        n_out_count  = r_count;
                        if (walk_last) begin
                            n_state = ST_IDLE;
                        end else begin
                            rd_addr = r_rd_next;
                            n_idx   = r_idx + SLOT_W'(1);
                        end
                    end
                end else if (r_rd_key == r_key) begin
                    n_res_status = STATUS_OK;
                    n_state      = ST_RESP;
                    if (r_kind == KIND_REMOVE) begin
                        // unlink the matched node from both neighbors
                        next_we         = 1'b1;
                        next_waddr      = r_rd_prev;
                        next_wdata      = r_rd_next;
                        prev_we         = 1'b1;
                        prev_waddr      = r_rd_next;
                        prev_wdata      = r_rd_prev;
                        n_used[r_cur]   = 1'b0;
                        n_count         = r_count - COUNT_W'(1);
                        if (r_count == COUNT_W'(1)) begin
                            n_head = '0;
                        end else if (r_cur == r_head) begin
                            n_head = r_rd_next;
                        end
                    end
                end else if (walk_last) begin
                    n_res_status = STATUS_ERR;
                    n_state      = ST_RESP;
                end else begin
                    rd_addr = r_rd_next;
                    n_idx   = r_idx + SLOT_W'(1);
                end
            end
            ST_ADD_A: begin
                // new node points at the head's old successor
                key_we     = 1'b1;
                key_waddr  = r_slot;
                next_we    = 1'b1;
                next_waddr = r_slot;
                next_wdata = after_slot;
                prev_we    = 1'b1;
                prev_waddr = after_slot;
                prev_wdata = r_slot;
                n_state    = ST_ADD_B;
            end
            ST_ADD_B: begin
                next_we        = 1'b1;
                next_waddr     = link_head;
                next_wdata     = r_slot;
                prev_we        = 1'b1;
                prev_waddr     = r_slot;
                prev_wdata     = link_head;
                n_used[r_slot] = 1'b1;
                n_count        = r_count + COUNT_W'(1);
                if (r_count == '0) begin
                    n_head = r_slot;
                end
                n_res_status   = STATUS_OK;
                n_state        = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    n_out_status = r_res_status;
                    n_out_key    = '0;
                    n_out_last   = 1'b1;
                    n_out_count  = r_count;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_key        <= n_key;
        r_slot       <= n_slot;
        r_idx        <= n_idx;
        r_cur        <= rd_addr;
        r_res_status <= n_res_status;
        r_out_status <= n_out_status;
        r_out_key    <= n_out_key;
        r_out_last   <= n_out_last;
        r_out_count  <= n_out_count;
    end

    // writes finish before the next word can issue a read, so no forwarding path
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[key_waddr] <= r_key;
        end
        r_rd_key <= key_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
        r_rd_next <= next_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        r_rd_prev <= prev_mem[rd_addr];
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_count, r_out_key};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_status;

    `CLE_ASSERT(a_used_matches_count, ($countones(r_used) == 32'(r_count)), "slot mask and count disagree")
    `CLE_ASSERT(a_empty_head_zero, ((r_count == '0) |-> (r_head == '0)), "empty list with nonzero head")
    `CLE_ASSERT_NEVER(a_count_range, (r_count > COUNT_W'(CAPACITY)), "count beyond capacity")
    `CLE_ASSERT(a_accept_leaves_idle, (in_accept |=> (r_state != ST_IDLE)), "accepted word not processed")
    `CLE_ASSERT(a_midwalk_ok, ((o_m_tvalid && !o_m_tlast) |-> (o_m_tuser == STATUS_OK)), "error on non-final word")

endmodule
`default_nettype wire

// ===== rtl/core/cle_free_slot.sv =====
// Lowest free slot finder over the slot occupancy mask.
`default_nettype none
module cle_free_slot
    import cle_pkg::*;
(
    input  wire logic [CAPACITY-1:0] i_used,
    output logic      [SLOT_W-1:0]   o_slot
);

    always_comb begin
        o_slot = '0;
        // scan downward so the lowest free slot wins
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!i_used[i]) begin
                o_slot = SLOT_W'(i);
            end
        end
    end

endmodule
`default_nettype wire

// ===== sim/circular_list_engine_core_tb.sv =====
// Self-checking testbench for the circular list engine core: scripted and random list operations.
module circular_list_engine_core_tb;
    import cle_pkg::*;

    localparam int RAND_ITEMS  = 420;
    localparam int FILL_AT     = 200;
    localparam int POOL_N      = 12;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 64;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
    } list_op_t;

    typedef struct packed {
        logic               status;
        logic [KEY_W-1:0]   item_key;
        logic               last;
        logic [COUNT_W-1:0] entry_count;
    } list_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              s_tvalid = 1'b0;
    logic [KEY_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0] s_tuser = '0;
    logic              m_tready = 1'b0;
    logic              s_tready;
    logic              m_tvalid;
    logic [39:0]       m_tdata;
    logic              m_tlast;
    logic [0:0]        m_tuser;

    list_op_t     pending_ops[$];
    list_result_t expected_results[$];

    // Shadow copy of the list
    logic [KEY_W-1:0]   key_mem [CAPACITY];
    logic [SLOT_W-1:0]  next_slot [CAPACITY];
    logic [SLOT_W-1:0]  prev_slot [CAPACITY];
    logic [CAPACITY-1:0] slot_busy = '0;
    logic [SLOT_W-1:0]  head_ptr = '0;
    logic [COUNT_W-1:0] key_total = '0;

    logic [KEY_W-1:0] key_pool [POOL_N];

    int n_errors = 0;
    int n_accepted = 0;
    int n_planned = 0;
    int quiet_cycles = 0;

    int send_gap_pct[4]   = '{0, 59, 0, 26};
    int recv_stall_pct[4] = '{0, 0, 59, 26};

    circular_list_engine_core u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // [31:0] key
        .i_s_tuser  (s_tuser),   // [2:0] kind
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),   // [31:0] item_key, [37:32] entry_count
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)    // [0] status
    );

    initial forever #5 clk = ~clk;

    function automatic int idle_phase();
        int ph;
        ph = (n_accepted * 4) / (n_planned + 1);
        return (ph > 3) ? 3 : ph;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return key_pool[$urandom_range(POOL_N - 1)];
        if (r < 95)
            return $urandom;
        return '0;
    endfunction

    task automatic queue_op(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
        list_op_t op;
        op.kind = kind;
        op.key  = key;
        pending_ops.push_back(op);
    endtask

    // Apply one operation to the shadow list and queue the words it should produce.
    task automatic list_apply(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
        logic ok;
        logic hit;
        logic walked;
        logic [SLOT_W-1:0] s;
        logic [SLOT_W-1:0] p;
        logic [SLOT_W-1:0] n;
        list_result_t res;
        int i;
        ok = 1'b0;
        hit = 1'b0;
        walked = 1'b0;
        s = '0;
        case (kind)
            KIND_ADD: begin
                if (key != '0 && key_total < CAPACITY) begin
                    for (i = CAPACITY - 1; i >= 0; i--)
                        if (!slot_busy[i]) s = SLOT_W'(i);
                    slot_busy[s] = 1'b1;
                    key_mem[s] = key;
                    if (key_total == 0) begin
                        head_ptr = s;
                        next_slot[s] = s;
                        prev_slot[s] = s;
                    end else begin
                        n = next_slot[head_ptr];
                        next_slot[s] = n;
                        prev_slot[s] = head_ptr;
                        next_slot[head_ptr] = s;
                        prev_slot[n] = s;
                    end
                    key_total = key_total + 1'b1;
                    ok = 1'b1;
                end
            end
            KIND_REMOVE, KIND_SEARCH: begin
                if (key != '0) begin
                    s = head_ptr;
                    for (i = 0; i < key_total && !hit; i++) begin
                        if (key_mem[s] == key)
                            hit = 1'b1;
                        else
                            s = next_slot[s];
                    end
                end
                ok = hit;
                if (hit && kind == KIND_REMOVE) begin
                    p = prev_slot[s];
                    n = next_slot[s];
                    next_slot[p] = n;
                    prev_slot[n] = p;
                    if (s == head_ptr)
                        head_ptr = n;
                    slot_busy[s] = 1'b0;
                    key_total = key_total - 1'b1;
                    if (key_total == 0)
                        head_ptr = '0;
                end
            end
            KIND_WALK: begin
                if (key_total != 0) begin
                    walked = 1'b1;
                    s = head_ptr;
                    for (i = 0; i < key_total; i++) begin
                        res.status      = STATUS_OK;
                        res.item_key    = key_mem[s];
                        res.last        = (i == key_total - 1);
                        res.entry_count = key_total;
                        expected_results.push_back(res);
                        s = next_slot[s];
                    end
                end
            end
            KIND_CLEAR: begin
                slot_busy = '0;
                head_ptr  = '0;
                key_total = '0;
                ok = 1'b1;
            end
            default: ok = 1'b0;
        endcase
        if (!walked) begin
            res.status      = ok ? STATUS_OK : STATUS_ERR;
            res.item_key    = '0;
            res.last        = 1'b1;
            res.entry_count = key_total;
            expected_results.push_back(res);
        end
    endtask

    // Driver: present queued words, with gaps per idle phase
    always @(posedge clk) begin : drive_ops
        list_op_t op;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                list_apply(s_tuser, s_tdata);
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_ops.size() != 0 &&
                    $urandom_range(99) >= send_gap_pct[idle_phase()]) begin
                    op = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= op.kind;
                    s_tdata  <= op.key;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result word with the oldest expectation
    always @(posedge clk) begin : watch_results
        list_result_t want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result word: tdata %h tlast %b tuser %b",
                           m_tdata, m_tlast, m_tuser);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser[0] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser[0]);
                        n_errors++;
                    end
                    if (m_tdata[31:0] !== want.item_key) begin
                        $error("item_key: expected %h, got %h", want.item_key, m_tdata[31:0]);
                        n_errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        n_errors++;
                    end
                    if (m_tdata[37:32] !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, m_tdata[37:32]);
                        n_errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct[idle_phase()]);
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : run_test
        int i;
        int r;
        logic grow;

        key_pool[0] = 32'hFFFF_FFFF;
        key_pool[1] = 32'h0000_0001;
        key_pool[2] = 32'h8000_0000;
        for (i = 3; i < POOL_N; i++)
            key_pool[i] = $urandom_range(32'hFFFF_FFFE, 1);

        // Empty-list errors, zero keys, duplicates, head removal, unknown kinds
        queue_op(KIND_WALK,   '0);
        queue_op(KIND_SEARCH, 32'h5);
        queue_op(KIND_REMOVE, 32'h5);
        queue_op(KIND_CLEAR,  '0);
        queue_op(KIND_ADD,    '0);
        queue_op(KIND_ADD,    32'hFFFF_FFFF);
        queue_op(KIND_ADD,    32'h0000_0001);
        queue_op(KIND_ADD,    32'h8000_0000);
        queue_op(KIND_ADD,    32'h0000_0001);
        queue_op(KIND_WALK,   $urandom);
        queue_op(KIND_SEARCH, '0);
        queue_op(KIND_REMOVE, '0);
        queue_op(KIND_SEARCH, 32'h8000_0000);
        queue_op(KIND_SEARCH, 32'h1234_5678);
        queue_op(KIND_REMOVE, 32'h0000_0001);
        queue_op(KIND_REMOVE, 32'hFFFF_FFFF);
        queue_op(KIND_WALK,   '0);
        queue_op(3'd5,        $urandom);
        queue_op(3'd6,        $urandom);
        queue_op(3'd7,        32'hFFFF_FFFF);
        queue_op(KIND_REMOVE, 32'h7);
        queue_op(KIND_CLEAR,  $urandom);
        queue_op(KIND_WALK,   '0);
        queue_op(KIND_ADD,    32'h5555_AAAA);

        for (i = 0; i < RAND_ITEMS; i++) begin
            if (i == FILL_AT) begin
                // Fill past capacity, then read the whole list back
                repeat (CAPACITY + 2)
                    queue_op(KIND_ADD, key_pool[$urandom_range(POOL_N - 1)]);
                queue_op(KIND_WALK, $urandom);
            end
            grow = ((i / 30) % 2) == 0;
            r = $urandom_range(99);
            if (r < (grow ? 55 : 15))
                queue_op(KIND_ADD, pick_key());
            else if (r < (grow ? 70 : 55))
                queue_op(KIND_REMOVE, pick_key());
            else if (r < (grow ? 85 : 75))
                queue_op(KIND_SEARCH, pick_key());
            else if (r < (grow ? 95 : 90))
                queue_op(KIND_WALK, $urandom);
            else if (r < (grow ? 97 : 92))
                queue_op(KIND_CLEAR, $urandom);
            else
                queue_op(KIND_W'($urandom_range(7, 5)), pick_key());
        end
        n_planned = pending_ops.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while ((pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0) &&
               quiet_cycles < QUIET_LIMIT)
            @(negedge clk);

        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("circular_list_engine_core_tb NOT OK");
        end else begin
            repeat (TAIL_CYCLES) @(negedge clk);
            if (n_errors == 0 && expected_results.size() == 0)
                $display("circular_list_engine_core_tb OK");
            else
                $display("circular_list_engine_core_tb NOT OK");
        end
        $finish;
    end

endmodule
